@@ hdl/isba_pkg.sv @@
// Package: sizes, constants and payload types of the IMU static bias averager.
package isba_pkg;

   // Sample and mean formats
   localparam int SAMPLE_BITS   = 16;
   localparam int FRACTION_BITS = 8;
   localparam int MEAN_BITS     = 24;
   localparam int COUNT_BITS    = 17;
   localparam int TARGET_BITS   = 16;
   localparam int AXES          = 6;
   localparam int AXIS_BITS     = $clog2(AXES);

   // Internal arithmetic widths
   localparam int FIX_BITS  = SAMPLE_BITS + FRACTION_BITS;
   localparam int WIDE_BITS = ((FIX_BITS > MEAN_BITS) ? FIX_BITS : MEAN_BITS) + 1;
   localparam int DIV_BITS  = WIDE_BITS - 1;
   localparam int STEP_BITS = $clog2(DIV_BITS + 1);
   localparam int SUM_BITS  = WIDE_BITS + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = TARGET_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SENSOR_ENABLE      = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INIT_SAMPLE_TARGET = 1'b1;

   localparam logic [TARGET_BITS-1:0] TARGET_RESET = TARGET_BITS'(100);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] acc_x;
      logic signed [SAMPLE_BITS-1:0] acc_y;
      logic signed [SAMPLE_BITS-1:0] acc_z;
      logic signed [SAMPLE_BITS-1:0] gyr_x;
      logic signed [SAMPLE_BITS-1:0] gyr_y;
      logic signed [SAMPLE_BITS-1:0] gyr_z;
      logic                          group_last;
   } req_type;

   typedef struct packed {
      logic signed [MEAN_BITS-1:0] mean_acc_x;
      logic signed [MEAN_BITS-1:0] mean_acc_y;
      logic signed [MEAN_BITS-1:0] mean_acc_z;
      logic signed [MEAN_BITS-1:0] mean_gyr_x;
      logic signed [MEAN_BITS-1:0] mean_gyr_y;
      logic signed [MEAN_BITS-1:0] mean_gyr_z;
      logic [COUNT_BITS-1:0]       samples_taken;
      logic                        init_done;
   } rsp_type;

endpackage

@@ hdl/imu_static_bias_averager.sv @@
// IMU static bias averager: six-axis cumulative mean with one shared serial divider.
// An averaged request is taken in idle, then per axis passes a load state, DIV_BITS
// restoring divide steps and an update state, and ends in the finish state; a disabled
// or finished request goes from idle straight to finish. One request is in work at a time;
// the response register lets the next request enter while a response waits.
// Reset (synchronous, active high) clears means, sets count to 1, enables averaging.
module imu_static_bias_averager (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  isba_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output isba_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_en,
   input  logic [isba_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [isba_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_UPD  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   localparam int MB = isba_pkg::MEAN_BITS;
   localparam int CB = isba_pkg::COUNT_BITS;
   localparam int WB = isba_pkg::WIDE_BITS;
   localparam int DB = isba_pkg::DIV_BITS;
   localparam int SB = isba_pkg::SUM_BITS;
   localparam logic [isba_pkg::AXIS_BITS-1:0] AXIS_LAST =
      isba_pkg::AXIS_BITS'(isba_pkg::AXES - 1);
   localparam logic [isba_pkg::STEP_BITS-1:0] STEP_LAST =
      isba_pkg::STEP_BITS'(DB - 1);
   localparam logic [CB-1:0] COUNT_ONE = isba_pkg::COUNT_ONE;

   // Saturate a wide value into the mean range
   function automatic logic signed [MB-1:0] sat_mean(input logic signed [SB-1:0] v);
      logic signed [SB-1:0] hi;
      logic signed [SB-1:0] lo;
      hi = SB'($signed({1'b0, {(MB-1){1'b1}}}));
      lo = SB'($signed({1'b1, {(MB-1){1'b0}}}));
      if (v > hi) begin
         sat_mean = hi[MB-1:0];
      end else if (v < lo) begin
         sat_mean = lo[MB-1:0];
      end else begin
         sat_mean = v[MB-1:0];
      end
   endfunction

   // State registers
   logic [2:0]                          state_ff, state_in;
   logic signed [MB-1:0]                means_ff [isba_pkg::AXES];
   logic signed [MB-1:0]                means_in [isba_pkg::AXES];
   logic [CB-1:0]                       count_ff, count_in;
   logic                                pending_ff, pending_in;
   logic                                finished_ff, finished_in;
   logic                                first_ff, first_in;
   logic                                enable_ff, enable_in;
   logic [isba_pkg::TARGET_BITS-1:0]    target_ff, target_in;
   isba_pkg::req_type                   req_ff, req_in;
   logic [isba_pkg::AXIS_BITS-1:0]      axis_ff, axis_in;
   logic [isba_pkg::STEP_BITS-1:0]      step_ff, step_in;
   logic [CB-1:0]                       rem_ff, rem_in;
   logic [DB-1:0]                       quo_ff, quo_in;
   logic                                neg_ff, neg_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   isba_pkg::rsp_type                   rsp_ff, rsp_in;

   // Datapath signals
   logic signed [isba_pkg::SAMPLE_BITS-1:0] samples [isba_pkg::AXES];
   logic signed [WB-1:0]                sample_fix;
   logic signed [MB-1:0]                mean_cur;
   logic signed [MB-1:0]                mean_eff;
   logic signed [WB-1:0]                diff;
   logic [CB:0]                         shifted;
   logic [CB+1:0]                       trial;
   logic signed [WB-1:0]                quo_signed;
   logic signed [SB-1:0]                sum;
   logic [CB-1:0]                       count_next;
   logic                                req_fire;
   logic                                out_free;

   assign samples[0] = req_ff.acc_x;
   assign samples[1] = req_ff.acc_y;
   assign samples[2] = req_ff.acc_z;
   assign samples[3] = req_ff.gyr_x;
   assign samples[4] = req_ff.gyr_y;
   assign samples[5] = req_ff.gyr_z;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Shared arithmetic: fixed-point sample, difference, one divide step, update sum
   assign sample_fix = WB'(samples[axis_ff]) <<< isba_pkg::FRACTION_BITS;
   assign mean_cur   = means_ff[axis_ff];
   assign mean_eff   = first_ff ? sat_mean(SB'(sample_fix)) : mean_cur;
   assign diff       = sample_fix - WB'(mean_eff);
   assign shifted    = {rem_ff, quo_ff[DB-1]};
   assign trial      = {1'b0, shifted} - {2'b00, count_ff};
   assign quo_signed = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign sum        = SB'(mean_cur) + SB'(quo_signed);
   assign count_next = (count_ff == isba_pkg::COUNT_MAX) ? count_ff : count_ff + COUNT_ONE;

   always_comb begin
      state_in     = state_ff;
      means_in     = means_ff;
      count_in     = count_ff;
      pending_in   = pending_ff;
      finished_in  = finished_ff;
      first_in     = first_ff;
      enable_in    = enable_ff;
      target_in    = target_ff;
      req_in       = req_ff;
      axis_in      = axis_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes
      if (csr_write_en) begin
         case (csr_index)
            isba_pkg::CSR_SENSOR_ENABLE:      enable_in = csr_wdata[0];
            isba_pkg::CSR_INIT_SAMPLE_TARGET: target_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // Take a request; average it only when enabled and not finished
            if (req_fire) begin
               req_in  = req_data;
               axis_in = '0;
               first_in = 1'b0;
               if (enable_ff && !finished_ff) begin
                  if (pending_ff) begin
                     count_in   = COUNT_ONE;
                     pending_in = 1'b0;
                     first_in   = 1'b1;
                  end
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_LOAD: begin
            // Form the difference magnitude for the current axis
            means_in[axis_ff] = mean_eff;
            neg_in  = diff[WB-1];
            quo_in  = diff[WB-1] ? DB'(-diff) : DB'(diff);
            rem_in  = '0;
            step_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // One restoring divide step per cycle
            if (!trial[CB+1]) begin
               rem_in = trial[CB-1:0];
               quo_in = {quo_ff[DB-2:0], 1'b1};
            end else begin
               rem_in = shifted[CB-1:0];
               quo_in = {quo_ff[DB-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            // Apply the quotient, then advance the axis or close the sample
            means_in[axis_ff] = sat_mean(sum);
            if (axis_ff == AXIS_LAST) begin
               count_in = count_next;
               if (req_ff.group_last && (count_next > CB'(target_ff))) begin
                  finished_in = 1'b1;
               end
               state_in = ST_FIN;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_FIN: begin
            // Hold until the response register is free, then load it
            if (out_free) begin
               rsp_in.mean_acc_x    = means_ff[0];
               rsp_in.mean_acc_y    = means_ff[1];
               rsp_in.mean_acc_z    = means_ff[2];
               rsp_in.mean_gyr_x    = means_ff[3];
               rsp_in.mean_gyr_y    = means_ff[4];
               rsp_in.mean_gyr_z    = means_ff[5];
               rsp_in.samples_taken = count_ff;
               rsp_in.init_done     = finished_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         means_ff     <= '{default: '0};
         count_ff     <= COUNT_ONE;
         pending_ff   <= 1'b1;
         finished_ff  <= 1'b0;
         first_ff     <= 1'b0;
         enable_ff    <= 1'b1;
         target_ff    <= isba_pkg::TARGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         means_ff     <= means_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         finished_ff  <= finished_in;
         first_ff     <= first_in;
         enable_ff    <= enable_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and divider registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      axis_ff <= axis_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

endmodule

@@ sim/tb_imu_static_bias_averager.sv @@
// Testbench: directed and random regression of the IMU static bias averager.
`timescale 1ns / 100ps

module tb_imu_static_bias_averager;

   localparam int SAMPLE_BITS    = isba_pkg::SAMPLE_BITS;
   localparam int FRACTION_BITS  = isba_pkg::FRACTION_BITS;
   localparam int MEAN_BITS      = isba_pkg::MEAN_BITS;
   localparam int COUNT_BITS     = isba_pkg::COUNT_BITS;
   localparam int TARGET_BITS    = isba_pkg::TARGET_BITS;
   localparam int AXES           = isba_pkg::AXES;
   localparam int CSR_INDEX_BITS = isba_pkg::CSR_INDEX_BITS;
   localparam int CSR_DATA_BITS  = isba_pkg::CSR_DATA_BITS;
   localparam logic [COUNT_BITS-1:0]  COUNT_ONE    = isba_pkg::COUNT_ONE;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = isba_pkg::COUNT_MAX;
   localparam logic [TARGET_BITS-1:0] TARGET_RESET = isba_pkg::TARGET_RESET;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 200;
   localparam int RANDOM_ITEMS   = 1250;
   localparam int TARGET_FLOOR   = 4000;
   localparam logic [TARGET_BITS-1:0] TARGET_MAX = {TARGET_BITS{1'b1}};
   localparam longint FIX_SCALE = longint'(1) << FRACTION_BITS;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic {STEP_CSR, STEP_SAMPLE} step_kind_type;

   typedef struct {
      step_kind_type             kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  value;
      isba_pkg::req_type         sample;
      bit                        typed;
      isba_pkg::rsp_type         result;
   } plan_row_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   isba_pkg::req_type         req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   isba_pkg::rsp_type         rsp_data;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // Predictor state and its copy of the registers
   logic signed [MEAN_BITS-1:0]   est_mean [AXES];
   logic [COUNT_BITS-1:0]         est_count;
   bit                            est_first;
   bit                            est_frozen;
   bit                            cfg_enable;
   logic [TARGET_BITS-1:0]        cfg_target;

   isba_pkg::rsp_type             awaited_means [$];
   logic signed [SAMPLE_BITS-1:0] axis_bias [AXES];
   bit                            quiet_phase;
   int                            error_count = 0;
   int                            idle_cycles = 0;
   int unsigned                   stall_left;

   imu_static_bias_averager uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // Clamp a wide mean into the signed mean range
   function automatic logic signed [MEAN_BITS-1:0] clamp_mean(input longint v);
      longint top;
      top = (longint'(1) << (MEAN_BITS - 1)) - 1;
      if (v > top) return MEAN_BITS'(top);
      if (v < -top - 1) return MEAN_BITS'(-top - 1);
      return MEAN_BITS'(v);
   endfunction

   // Fold one request into the running means and return the response it yields
   function automatic isba_pkg::rsp_type advance_bias_estimate(input isba_pkg::req_type smp);
      longint            raw [AXES];
      longint            divisor;
      isba_pkg::rsp_type est;
      raw[0] = longint'(smp.acc_x) * FIX_SCALE;
      raw[1] = longint'(smp.acc_y) * FIX_SCALE;
      raw[2] = longint'(smp.acc_z) * FIX_SCALE;
      raw[3] = longint'(smp.gyr_x) * FIX_SCALE;
      raw[4] = longint'(smp.gyr_y) * FIX_SCALE;
      raw[5] = longint'(smp.gyr_z) * FIX_SCALE;
      if (cfg_enable && !est_frozen) begin
         // first averaged sample loads the means and restarts the count
         if (est_first) begin
            foreach (est_mean[i]) est_mean[i] = clamp_mean(raw[i]);
            est_count = COUNT_ONE;
            est_first = 1'b0;
         end
         divisor = (est_count == '0) ? 1 : longint'(est_count);
         // signed division truncates toward zero
         foreach (est_mean[i])
            est_mean[i] = clamp_mean(longint'(est_mean[i]) +
                                     (raw[i] - longint'(est_mean[i])) / divisor);
         if (est_count != COUNT_MAX) est_count = est_count + 1'b1;
         if (smp.group_last && est_count > cfg_target) est_frozen = 1'b1;
      end
      est.mean_acc_x    = est_mean[0];
      est.mean_acc_y    = est_mean[1];
      est.mean_acc_z    = est_mean[2];
      est.mean_gyr_x    = est_mean[3];
      est.mean_gyr_y    = est_mean[4];
      est.mean_gyr_z    = est_mean[5];
      est.samples_taken = est_count;
      est.init_done     = est_frozen;
      return est;
   endfunction

   function automatic isba_pkg::req_type sample(input int ax, input int ay, input int az,
                                                input int gx, input int gy, input int gz,
                                                input bit last);
      isba_pkg::req_type smp;
      smp.acc_x      = SAMPLE_BITS'(ax);
      smp.acc_y      = SAMPLE_BITS'(ay);
      smp.acc_z      = SAMPLE_BITS'(az);
      smp.gyr_x      = SAMPLE_BITS'(gx);
      smp.gyr_y      = SAMPLE_BITS'(gy);
      smp.gyr_z      = SAMPLE_BITS'(gz);
      smp.group_last = last;
      return smp;
   endfunction

   // Draw one sample: mostly noise around the phase bias, some full range, some extremes
   function automatic isba_pkg::req_type random_sample();
      isba_pkg::req_type             smp;
      logic signed [SAMPLE_BITS-1:0] axis [AXES];
      int                            noise;
      foreach (axis[i]) begin
         noise = int'($urandom_range(0, 127)) - 64;
         case ($urandom_range(0, 9))
            0, 1: axis[i] = SAMPLE_BITS'($urandom);
            2: axis[i] = ($urandom_range(0, 1) == 0) ? SAMPLE_MAX : SAMPLE_MIN;
            default: axis[i] = SAMPLE_BITS'(int'(axis_bias[i]) + noise);
         endcase
      end
      smp = sample(axis[0], axis[1], axis[2], axis[3], axis[4], axis[5],
                   $urandom_range(0, 3) == 0);
      return smp;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_INDEX_BITS-1:0] index,
                                            input int value);
      plan_row_type row;
      row.kind   = STEP_CSR;
      row.index  = index;
      row.value  = CSR_DATA_BITS'(value);
      row.sample = '0;
      row.typed  = 1'b0;
      row.result = '0;
      return row;
   endfunction

   function automatic plan_row_type sample_row(input isba_pkg::req_type smp);
      plan_row_type row;
      row.kind   = STEP_SAMPLE;
      row.index  = '0;
      row.value  = '0;
      row.sample = smp;
      row.typed  = 1'b0;
      row.result = '0;
      return row;
   endfunction

   // Row whose response is known up front: same mean on all accel axes and all gyro axes
   function automatic plan_row_type typed_row(input isba_pkg::req_type smp, input int acc_mean,
                                              input int gyr_mean, input int count,
                                              input bit done);
      plan_row_type row;
      row                      = sample_row(smp);
      row.typed                = 1'b1;
      row.result.mean_acc_x    = MEAN_BITS'(acc_mean);
      row.result.mean_acc_y    = MEAN_BITS'(acc_mean);
      row.result.mean_acc_z    = MEAN_BITS'(acc_mean);
      row.result.mean_gyr_x    = MEAN_BITS'(gyr_mean);
      row.result.mean_gyr_y    = MEAN_BITS'(gyr_mean);
      row.result.mean_gyr_z    = MEAN_BITS'(gyr_mean);
      row.result.samples_taken = COUNT_BITS'(count);
      row.result.init_done     = done;
      return row;
   endfunction

   // Present one request, hold it until accepted, then queue its expected response
   task automatic send_sample(input isba_pkg::req_type smp, input bit typed,
                              input isba_pkg::rsp_type typed_rsp);
      int unsigned       gap;
      isba_pkg::rsp_type model_rsp;
      gap = quiet_phase ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= smp;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      model_rsp = advance_bias_estimate(smp);
      awaited_means.push_back(typed ? typed_rsp : model_rsp);
   endtask

   // Drain all outstanding responses, then write one register
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      req_valid <= 1'b0;
      while (awaited_means.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (index == isba_pkg::CSR_SENSOR_ENABLE) cfg_enable = value[0];
      else cfg_target = value[TARGET_BITS-1:0];
   endtask

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // Stall the response side for a drawn number of cycles per response
   always @(posedge clock) begin : rsp_stall
      int unsigned draw;
      if (reset) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         draw = quiet_phase ? 0 : $urandom_range(0, 4);
         stall_left <= draw;
         rsp_ready  <= (draw == 0);
      end else if (rsp_valid) begin
         if (stall_left <= 1) begin
            rsp_ready  <= 1'b1;
            stall_left <= 0;
         end else begin
            stall_left <= stall_left - 1;
         end
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      isba_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_means.size() == 0) begin
            $display("%0t: response with none expected, expected none, actual %h",
                     $time, rsp_data);
            error_count++;
         end else begin
            want = awaited_means.pop_front();
            check_field("mean_acc_x", want.mean_acc_x, rsp_data.mean_acc_x);
            check_field("mean_acc_y", want.mean_acc_y, rsp_data.mean_acc_y);
            check_field("mean_acc_z", want.mean_acc_z, rsp_data.mean_acc_z);
            check_field("mean_gyr_x", want.mean_gyr_x, rsp_data.mean_gyr_x);
            check_field("mean_gyr_y", want.mean_gyr_y, rsp_data.mean_gyr_y);
            check_field("mean_gyr_z", want.mean_gyr_z, rsp_data.mean_gyr_z);
            check_field("samples_taken", want.samples_taken, rsp_data.samples_taken);
            check_field("init_done", want.init_done, rsp_data.init_done);
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT - 1) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      plan_row_type           bring_up_plan [$];
      int unsigned            averaged_items;
      int unsigned            phase_len;
      bit                     enable_next;
      logic [TARGET_BITS-1:0] target_next;
      isba_pkg::req_type      tail_sample;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      quiet_phase  = 1'b0;
      foreach (est_mean[i]) est_mean[i] = '0;
      foreach (axis_bias[i]) axis_bias[i] = '0;
      est_count      = COUNT_ONE;
      est_first      = 1'b1;
      est_frozen     = 1'b0;
      cfg_enable     = 1'b1;
      cfg_target     = TARGET_RESET;
      averaged_items = 0;

      // Directed plan: reset state, ignored group ends, extremes, first sample load
      bring_up_plan.push_back(csr_row(isba_pkg::CSR_SENSOR_ENABLE, 0));
      bring_up_plan.push_back(typed_row(sample(1234, 1234, 1234, -1234, -1234, -1234, 1),
                                        0, 0, 1, 1'b0));
      bring_up_plan.push_back(csr_row(isba_pkg::CSR_INIT_SAMPLE_TARGET, 1));
      bring_up_plan.push_back(typed_row(sample(-1, -1, -1, 1, 1, 1, 1), 0, 0, 1, 1'b0));
      bring_up_plan.push_back(csr_row(isba_pkg::CSR_INIT_SAMPLE_TARGET, 0));
      bring_up_plan.push_back(typed_row(sample(0, 0, 0, 0, 0, 0, 1), 0, 0, 1, 1'b0));
      bring_up_plan.push_back(csr_row(isba_pkg::CSR_INIT_SAMPLE_TARGET, TARGET_MAX));
      bring_up_plan.push_back(csr_row(isba_pkg::CSR_SENSOR_ENABLE, 1));
      bring_up_plan.push_back(typed_row(sample(32767, 32767, 32767, -32768, -32768, -32768, 0),
                                        8388352, -8388608, 2, 1'b0));
      bring_up_plan.push_back(sample_row(sample(-32768, -32768, -32768, 32767, 32767, 32767, 1)));
      bring_up_plan.push_back(sample_row(sample(1, -1, 32767, -32768, 255, -256, 0)));
      bring_up_plan.push_back(sample_row(sample(0, 0, 0, 0, 0, 0, 1)));
      bring_up_plan.push_back(sample_row(sample(-1, -1, -1, -1, -1, -1, 0)));
      bring_up_plan.push_back(sample_row(sample(1, 1, 1, -1, -1, -1, 1)));
      bring_up_plan.push_back(sample_row(sample(21845, -21846, 21845, -21846, 21845, -21846, 0)));
      bring_up_plan.push_back(csr_row(isba_pkg::CSR_INIT_SAMPLE_TARGET, TARGET_RESET));
      bring_up_plan.push_back(sample_row(sample(32767, 32767, 32767, 32767, 32767, 32767, 1)));
      bring_up_plan.push_back(sample_row(sample(-32768, 0, 32767, -32768, 0, 32767, 1)));

      // Hold reset, then release
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed plan
      foreach (bring_up_plan[i]) begin
         if (bring_up_plan[i].kind == STEP_CSR)
            write_csr(bring_up_plan[i].index, bring_up_plan[i].value);
         else
            send_sample(bring_up_plan[i].sample, bring_up_plan[i].typed,
                        bring_up_plan[i].result);
      end

      // Random phases; targets stay above any reachable count so averaging never stops
      while (averaged_items < RANDOM_ITEMS) begin
         enable_next = ($urandom_range(0, 5) != 0);
         target_next = ($urandom_range(0, 2) == 0) ? TARGET_MAX :
                       TARGET_BITS'($urandom_range(TARGET_FLOOR, 65535));
         write_csr(isba_pkg::CSR_SENSOR_ENABLE, CSR_DATA_BITS'(enable_next));
         write_csr(isba_pkg::CSR_INIT_SAMPLE_TARGET, target_next);
         quiet_phase = ($urandom_range(0, 3) == 0);
         foreach (axis_bias[i]) axis_bias[i] = SAMPLE_BITS'($urandom);
         phase_len = enable_next ? $urandom_range(20, 120) : $urandom_range(4, 16);
         repeat (phase_len) begin
            send_sample(random_sample(), 1'b0, '0);
            if (cfg_enable) averaged_items++;
         end
      end

      // Finish boundary: count equal to target stays open, exceeding it at a group end freezes
      quiet_phase = 1'b0;
      write_csr(isba_pkg::CSR_SENSOR_ENABLE, 1);
      write_csr(isba_pkg::CSR_INIT_SAMPLE_TARGET, CSR_DATA_BITS'(est_count + 1'b1));
      tail_sample = random_sample();
      tail_sample.group_last = 1'b1;
      send_sample(tail_sample, 1'b0, '0);
      tail_sample = random_sample();
      tail_sample.group_last = 1'b0;
      send_sample(tail_sample, 1'b0, '0);
      tail_sample = random_sample();
      tail_sample.group_last = 1'b1;
      send_sample(tail_sample, 1'b0, '0);

      // Frozen means must hold whatever arrives
      repeat (12) send_sample(random_sample(), 1'b0, '0);
      write_csr(isba_pkg::CSR_SENSOR_ENABLE, 0);
      repeat (3) send_sample(random_sample(), 1'b0, '0);
      write_csr(isba_pkg::CSR_SENSOR_ENABLE, 1);
      repeat (3) send_sample(random_sample(), 1'b0, '0);

      // Drain and let the block settle before the verdict
      req_valid <= 1'b0;
      while (awaited_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
